FILE: sv/wse_pkg.sv
// Shared types and constants of the stack executor: opcode bytes, item kinds,
// instruction classes, status codes, the queue and stack entries and the configuration. No dependencies.
package wse_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int MAX_LOCALS  = 16;

    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int AW      = $clog2(STACK_DEPTH);
    localparam int LI_W    = (MAX_LOCALS > 1) ? $clog2(MAX_LOCALS) : 1;
    localparam int LIU_W   = $clog2(MAX_LOCALS + 1);
    localparam int DEPTH_W = 7;
    localparam int CFG_W   = 5;

    localparam logic [7:0] OP_NOP       = 8'h00;
    localparam logic [7:0] OP_END       = 8'h0B;
    localparam logic [7:0] OP_RETURN    = 8'h0F;
    localparam logic [7:0] OP_DROP      = 8'h1A;
    localparam logic [7:0] OP_LOCAL_GET = 8'h20;
    localparam logic [7:0] OP_LOCAL_SET = 8'h21;
    localparam logic [7:0] OP_LOCAL_TEE = 8'h22;
    localparam logic [7:0] OP_I32_CONST = 8'h41;
    localparam logic [7:0] OP_I64_CONST = 8'h42;
    localparam logic [7:0] OP_I32_EQZ   = 8'h45;
    localparam logic [7:0] OP_I32_EQ    = 8'h46;
    localparam logic [7:0] OP_I32_NE    = 8'h47;
    localparam logic [7:0] OP_I32_LT_S  = 8'h48;
    localparam logic [7:0] OP_I32_LT_U  = 8'h49;
    localparam logic [7:0] OP_I32_GT_S  = 8'h4A;
    localparam logic [7:0] OP_I32_GT_U  = 8'h4B;
    localparam logic [7:0] OP_I32_LE_S  = 8'h4C;
    localparam logic [7:0] OP_I32_LE_U  = 8'h4D;
    localparam logic [7:0] OP_I32_GE_S  = 8'h4E;
    localparam logic [7:0] OP_I32_GE_U  = 8'h4F;
    localparam logic [7:0] OP_I32_CLZ   = 8'h67;
    localparam logic [7:0] OP_I32_ADD   = 8'h6A;
    localparam logic [7:0] OP_I32_SUB   = 8'h6B;
    localparam logic [7:0] OP_I32_MUL   = 8'h6C;
    localparam logic [7:0] OP_I32_DIV_S = 8'h6D;
    localparam logic [7:0] OP_I32_DIV_U = 8'h6E;
    localparam logic [7:0] OP_I32_AND   = 8'h71;
    localparam logic [7:0] OP_I32_OR    = 8'h72;
    localparam logic [7:0] OP_I32_XOR   = 8'h73;
    localparam logic [7:0] OP_I32_SHL   = 8'h74;
    localparam logic [7:0] OP_I32_SHR_S = 8'h75;
    localparam logic [7:0] OP_I32_SHR_U = 8'h76;
    localparam logic [7:0] OP_I64_ADD   = 8'h7C;
    localparam logic [7:0] OP_I64_SUB   = 8'h7D;
    localparam logic [7:0] OP_I64_MUL   = 8'h7E;
    localparam logic [7:0] OP_I64_AND   = 8'h83;
    localparam logic [7:0] OP_I64_OR    = 8'h84;
    localparam logic [7:0] OP_I64_XOR   = 8'h85;

    typedef enum logic [1:0] {
        K_PUSH  = 2'd0,
        K_FRAME = 2'd1,
        K_EXEC  = 2'd2,
        K_POP   = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        OC_NOP, OC_END, OC_DROP, OC_LGET, OC_LSET, OC_LTEE, OC_C32, OC_C64,
        OC_EQZ, OC_CLZ, OC_I32BIN, OC_I64BIN, OC_BAD
    } t_opc;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_DONE   = 3'd1,
        ST_ERR    = 3'd2,
        ST_OVF    = 3'd3,
        ST_LOCALS = 3'd4
    } t_status;

    typedef struct packed {
        t_kind       kind;
        t_opc        opc;
        logic [7:0]  opcode;
        logic [63:0] imm;
        logic        otype;
        logic [63:0] oval;
    } t_cmd;

    typedef struct packed {
        logic [CFG_W-1:0] arg_count;
        logic [CFG_W-1:0] extra_local_count;
    } t_cfg;

    typedef struct packed {
        logic        t;
        logic [63:0] v;
    } t_entry;

endpackage

FILE: sv/wse_chan_if.sv
// Handshake channels of the stack executor: the item channel and the result
// channel. Depends on nothing but plain logic types.
interface wse_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  opcode;
    logic signed [63:0] immediate;
    logic        operand_type;
    logic signed [63:0] operand_value;

    modport source(output valid, kind, opcode, immediate, operand_type, operand_value,
                   input ready);
    modport sink(input valid, kind, opcode, immediate, operand_type, operand_value,
                 output ready);
endinterface

interface wse_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic signed [63:0] result_value;
    logic        result_type;
    logic [6:0]  stack_depth;
    logic [6:0]  peak_depth;

    modport source(output valid, status, result_value, result_type, stack_depth, peak_depth,
                   input ready);
    modport sink(input valid, status, result_value, result_type, stack_depth, peak_depth,
                 output ready);
endinterface

FILE: sv/wse_regs.sv
// Configuration registers behind the APB-style port.
// Depends on wse_pkg for the configuration struct.
module wse_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output wse_pkg::t_cfg        o_cfg
);
    import wse_pkg::*;

    localparam logic REG_ARG_COUNT   = 1'b0;
    localparam logic REG_EXTRA_LOCAL = 1'b1;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_ARG_COUNT:   n_cfg.arg_count         = pwdata[CFG_W-1:0];
                REG_EXTRA_LOCAL: n_cfg.extra_local_count = pwdata[CFG_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ARG_COUNT:   prdata = 32'(r_cfg.arg_count);
            REG_EXTRA_LOCAL: prdata = 32'(r_cfg.extra_local_count);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: sv/wse_front.sv
// Front end: accepts items, classifies the opcode and queues them in a
// two-entry queue for the execution unit. Depends on wse_pkg and wse_in_if.
module wse_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wse_in_if.sink        in_ch,
    output logic          o_q_valid,
    output wse_pkg::t_cmd o_q_cmd,
    input  logic          i_q_ready
);
    import wse_pkg::*;

    t_cmd       r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       cmd;
    logic       push, pop;

    function automatic t_opc classify(input logic [7:0] op);
        case (op)
            OP_NOP:                    classify = OC_NOP;
            OP_END, OP_RETURN:         classify = OC_END;
            OP_DROP:                   classify = OC_DROP;
            OP_LOCAL_GET:              classify = OC_LGET;
            OP_LOCAL_SET:              classify = OC_LSET;
            OP_LOCAL_TEE:              classify = OC_LTEE;
            OP_I32_CONST:              classify = OC_C32;
            OP_I64_CONST:              classify = OC_C64;
            OP_I32_EQZ:                classify = OC_EQZ;
            OP_I32_CLZ:                classify = OC_CLZ;
            OP_I32_EQ, OP_I32_NE, OP_I32_LT_S, OP_I32_LT_U, OP_I32_GT_S, OP_I32_GT_U,
            OP_I32_LE_S, OP_I32_LE_U, OP_I32_GE_S, OP_I32_GE_U,
            OP_I32_ADD, OP_I32_SUB, OP_I32_MUL, OP_I32_DIV_S, OP_I32_DIV_U,
            OP_I32_AND, OP_I32_OR, OP_I32_XOR, OP_I32_SHL, OP_I32_SHR_S, OP_I32_SHR_U:
                                       classify = OC_I32BIN;
            OP_I64_ADD, OP_I64_SUB, OP_I64_MUL, OP_I64_AND, OP_I64_OR, OP_I64_XOR:
                                       classify = OC_I64BIN;
            default:                   classify = OC_BAD;
        endcase
    endfunction

    always_comb begin
        cmd.kind   = t_kind'(in_ch.kind);
        cmd.opc    = classify(in_ch.opcode);
        cmd.opcode = in_ch.opcode;
        cmd.imm    = in_ch.immediate;
        cmd.otype  = in_ch.operand_type;
        cmd.oval   = in_ch.operand_value;
    end

    assign in_ch.ready = (r_cnt != 2'd2);
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_cmd     = r_buf[r_rp];
    assign push        = in_ch.valid && in_ch.ready;
    assign pop         = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: sv/wse_back.sv
// Execution unit: sequencer over the operand stack memory, the locals, a
// cached top of stack, a bit-serial divider, a shared 32x32 multiplier and the
// result register. Depends on wse_pkg and wse_out_if.
module wse_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wse_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  wse_pkg::t_cmd i_q_cmd,
    output logic          o_q_ready,
    wse_out_if.source     out_ch
);
    import wse_pkg::*;

    localparam int CNT_W = 6;

    typedef enum logic [3:0] {
        S_IDLE, S_FRM, S_FRM2, S_REFILL, S_REF2, S_RD2, S_BIN, S_DIV, S_MUL, S_CLZ, S_OUT
    } t_state;

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [SP_W-1:0]  r_sp, n_sp, r_peak, n_peak;
    t_entry           r_top, n_top, r_pv, n_pv;
    logic             r_frame, n_frame;
    logic [LIU_W-1:0] r_liu, n_liu;
    logic [63:0]      r_lv [MAX_LOCALS];
    logic [63:0]      n_lv [MAX_LOCALS];
    logic             r_lt [MAX_LOCALS];
    logic             n_lt [MAX_LOCALS];
    t_status          r_st, n_st;
    logic             r_popped, n_popped;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [63:0]      r_acc, n_acc, r_opa, n_opa;
    logic [31:0]      r_dvs, n_dvs, r_rem, n_rem;
    logic             r_neg, n_neg;
    logic [1:0]       r_mstep, n_mstep;
    logic             r_ov, n_ov;
    logic [2:0]       r_o_st, n_o_st;
    logic [63:0]      r_o_val, n_o_val;
    logic             r_o_t, n_o_t;
    logic [DEPTH_W-1:0] r_o_dep, n_o_dep, r_o_pk, n_o_pk;

    t_entry           r_mem [STACK_DEPTH];
    t_entry           r_rdata;
    logic             we;
    logic [AW-1:0]    waddr, raddr;
    t_entry           wdata;

    logic [31:0]      mul_a, mul_b;
    logic [63:0]      mul_p;

    assign mul_p = mul_a * mul_b;

    function automatic logic [63:0] sx32(input logic [31:0] v);
        sx32 = {{32{v[31]}}, v};
    endfunction

    function automatic logic [2:0] lz4(input logic [3:0] n);
        case (n)
            4'b0000:                            lz4 = 3'd4;
            4'b0001:                            lz4 = 3'd3;
            4'b0010, 4'b0011:                   lz4 = 3'd2;
            4'b0100, 4'b0101, 4'b0110, 4'b0111: lz4 = 3'd1;
            default:                            lz4 = 3'd0;
        endcase
    endfunction

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[raddr];
    end

    assign out_ch.valid        = r_ov;
    assign out_ch.status       = r_o_st;
    assign out_ch.result_value = r_o_val;
    assign out_ch.result_type  = r_o_t;
    assign out_ch.stack_depth  = r_o_dep;
    assign out_ch.peak_depth   = r_o_pk;
    assign o_q_ready           = (r_state == S_IDLE);

    always_comb begin
        logic [SP_W-1:0]  sp_m1, sp_m2;
        logic [CNT_W-1:0] cnt_m1;
        logic             full;
        logic             psh, fin_bin, fin_top;
        t_entry           res;
        logic [CFG_W:0]   total;
        logic [31:0]      a32, b32, r32, qv;
        logic [63:0]      r64;
        logic             ok;
        logic [32:0]      rs, diff;
        logic [3:0]       nib;
        logic [CNT_W-1:0] zc;
        t_cmd             c;

        n_state = r_state;  n_cmd = r_cmd;   n_sp = r_sp;       n_peak = r_peak;
        n_top = r_top;      n_pv = r_pv;     n_frame = r_frame; n_liu = r_liu;
        n_lv = r_lv;        n_lt = r_lt;     n_st = r_st;       n_popped = r_popped;
        n_cnt = r_cnt;      n_acc = r_acc;   n_opa = r_opa;     n_dvs = r_dvs;
        n_rem = r_rem;      n_neg = r_neg;   n_mstep = r_mstep;
        n_ov = r_ov;        n_o_st = r_o_st; n_o_val = r_o_val; n_o_t = r_o_t;
        n_o_dep = r_o_dep;  n_o_pk = r_o_pk;
        we = 1'b0;  waddr = '0;  wdata = '0;  raddr = '0;
        mul_a = '0; mul_b = '0;

        sp_m1  = r_sp - 1'b1;
        sp_m2  = r_sp - 2'd2;
        cnt_m1 = r_cnt - 1'b1;
        full   = (r_sp >= SP_W'(STACK_DEPTH));
        psh = 1'b0;  fin_bin = 1'b0;  fin_top = 1'b0;
        res = '0;
        total = {1'b0, i_cfg.arg_count} + {1'b0, i_cfg.extra_local_count};
        a32 = r_rdata.v[31:0];
        b32 = r_top.v[31:0];
        r32 = '0;  r64 = '0;  qv = '0;  ok = 1'b1;
        rs = '0;  diff = '0;  nib = r_acc[31:28];  zc = '0;
        c = i_q_cmd;

        if (r_ov && out_ch.ready) n_ov = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_cmd    = c;
                    n_popped = 1'b0;
                    n_state  = S_OUT;
                    n_st     = ST_OK;
                    case (c.kind)
                        K_PUSH: begin
                            if (full) begin
                                n_st = ST_OVF;
                            end else begin
                                psh = 1'b1;
                                res = {c.otype, c.otype ? c.oval : sx32(c.oval[31:0])};
                            end
                        end
                        K_POP: begin
                            if (r_sp == '0) begin
                                n_st = ST_ERR;
                            end else begin
                                n_popped = 1'b1;
                                n_pv     = r_top;
                                n_sp     = sp_m1;
                                n_state  = S_REFILL;
                            end
                        end
                        K_FRAME: begin
                            if (32'(total) > MAX_LOCALS) begin
                                n_st = ST_LOCALS;
                            end else if (r_sp < SP_W'(i_cfg.arg_count)) begin
                                n_st = ST_ERR;
                            end else begin
                                for (int j = 0; j < MAX_LOCALS; j++) begin
                                    if (j >= int'(i_cfg.arg_count) && j < int'(total)) begin
                                        n_lv[j] = '0;
                                        n_lt[j] = 1'b0;
                                    end
                                end
                                n_cnt   = CNT_W'(i_cfg.arg_count);
                                n_liu   = LIU_W'(total);
                                n_state = S_FRM;
                            end
                        end
                        K_EXEC: begin
                            if (!r_frame) begin
                                n_st = ST_ERR;
                            end else begin
                                case (c.opc)
                                    OC_NOP: n_st = ST_OK;
                                    OC_END: begin
                                        n_frame = 1'b0;
                                        n_st    = ST_DONE;
                                    end
                                    OC_DROP: begin
                                        if (r_sp == '0) begin
                                            n_st = ST_ERR;
                                        end else begin
                                            n_sp    = sp_m1;
                                            n_state = S_REFILL;
                                        end
                                    end
                                    OC_LGET: begin
                                        if (c.imm >= 64'(r_liu)) begin
                                            n_st = ST_ERR;
                                        end else if (full) begin
                                            n_st = ST_OVF;
                                        end else begin
                                            psh = 1'b1;
                                            res = {r_lt[c.imm[LI_W-1:0]], r_lv[c.imm[LI_W-1:0]]};
                                        end
                                    end
                                    OC_LSET, OC_LTEE: begin
                                        if (c.imm >= 64'(r_liu) || r_sp == '0) begin
                                            n_st = ST_ERR;
                                        end else begin
                                            n_lv[c.imm[LI_W-1:0]] = r_top.v;
                                            n_lt[c.imm[LI_W-1:0]] = r_top.t;
                                            if (c.opc == OC_LSET) begin
                                                n_sp    = sp_m1;
                                                n_state = S_REFILL;
                                            end
                                        end
                                    end
                                    OC_C32, OC_C64: begin
                                        if (full) begin
                                            n_st = ST_OVF;
                                        end else begin
                                            psh = 1'b1;
                                            if (c.opc == OC_C32) res = {1'b0, sx32(c.imm[31:0])};
                                            else                 res = {1'b1, c.imm};
                                        end
                                    end
                                    OC_EQZ, OC_CLZ: begin
                                        if (r_sp == '0 || r_top.t) begin
                                            n_st = ST_ERR;
                                        end else if (c.opc == OC_EQZ) begin
                                            fin_top = 1'b1;
                                            res = {1'b0, 63'd0, (b32 == 32'd0)};
                                        end else begin
                                            n_acc   = {32'd0, b32};
                                            n_cnt   = '0;
                                            n_state = S_CLZ;
                                        end
                                    end
                                    OC_I32BIN, OC_I64BIN: begin
                                        if (r_sp < SP_W'(2) || r_top.t != (c.opc == OC_I64BIN)) begin
                                            n_st = ST_ERR;
                                        end else begin
                                            n_state = S_RD2;
                                        end
                                    end
                                    default: n_st = ST_ERR;
                                endcase
                            end
                        end
                        default: n_st = ST_ERR;
                    endcase
                end
            end

            // Parameters move one at a time, deepest last, so the read address is the
            // current top while the count, less one, indexes the local it fills.
            S_FRM: begin
                if (r_cnt == '0) begin
                    n_frame = 1'b1;
                    n_state = S_REFILL;
                end else begin
                    raddr   = sp_m1[AW-1:0];
                    n_state = S_FRM2;
                end
            end
            S_FRM2: begin
                n_lv[cnt_m1[LI_W-1:0]] = r_rdata.v;
                n_lt[cnt_m1[LI_W-1:0]] = r_rdata.t;
                n_sp    = sp_m1;
                n_cnt   = cnt_m1;
                n_state = S_FRM;
            end

            S_REFILL: begin
                if (r_sp == '0) begin
                    n_state = S_OUT;
                end else begin
                    raddr   = sp_m1[AW-1:0];
                    n_state = S_REF2;
                end
            end
            S_REF2: begin
                n_top   = r_rdata;
                n_state = S_OUT;
            end

            S_RD2: begin
                raddr   = sp_m2[AW-1:0];
                n_state = S_BIN;
            end

            S_BIN: begin
                n_state = S_OUT;
                if (r_rdata.t != (r_cmd.opc == OC_I64BIN)) begin
                    n_st = ST_ERR;
                end else if (r_cmd.opc == OC_I32BIN) begin
                    case (r_cmd.opcode)
                        OP_I32_EQ:    r32 = 32'(a32 == b32);
                        OP_I32_NE:    r32 = 32'(a32 != b32);
                        OP_I32_LT_S:  r32 = 32'($signed(a32) < $signed(b32));
                        OP_I32_LT_U:  r32 = 32'(a32 < b32);
                        OP_I32_GT_S:  r32 = 32'($signed(a32) > $signed(b32));
                        OP_I32_GT_U:  r32 = 32'(a32 > b32);
                        OP_I32_LE_S:  r32 = 32'($signed(a32) <= $signed(b32));
                        OP_I32_LE_U:  r32 = 32'(a32 <= b32);
                        OP_I32_GE_S:  r32 = 32'($signed(a32) >= $signed(b32));
                        OP_I32_GE_U:  r32 = 32'(a32 >= b32);
                        OP_I32_ADD:   r32 = a32 + b32;
                        OP_I32_SUB:   r32 = a32 - b32;
                        OP_I32_MUL: begin
                            mul_a = a32;
                            mul_b = b32;
                            r32   = mul_p[31:0];
                        end
                        OP_I32_AND:   r32 = a32 & b32;
                        OP_I32_OR:    r32 = a32 | b32;
                        OP_I32_XOR:   r32 = a32 ^ b32;
                        OP_I32_SHL:   r32 = a32 << b32[4:0];
                        OP_I32_SHR_S: r32 = 32'($signed(a32) >>> b32[4:0]);
                        OP_I32_SHR_U: r32 = a32 >> b32[4:0];
                        OP_I32_DIV_S, OP_I32_DIV_U: begin
                            ok = 1'b0;
                            if (b32 == 32'd0 || (r_cmd.opcode == OP_I32_DIV_S &&
                                    a32 == 32'h8000_0000 && b32 == 32'hFFFF_FFFF)) begin
                                n_st = ST_ERR;
                            end else begin
                                if (r_cmd.opcode == OP_I32_DIV_S) begin
                                    n_acc = {32'd0, a32[31] ? 32'd0 - a32 : a32};
                                    n_dvs = b32[31] ? 32'd0 - b32 : b32;
                                    n_neg = a32[31] ^ b32[31];
                                end else begin
                                    n_acc = {32'd0, a32};
                                    n_dvs = b32;
                                    n_neg = 1'b0;
                                end
                                n_rem   = '0;
                                n_cnt   = '0;
                                n_state = S_DIV;
                            end
                        end
                        default: begin
                            ok   = 1'b0;
                            n_st = ST_ERR;
                        end
                    endcase
                    if (ok) begin
                        fin_bin = 1'b1;
                        res = {1'b0, sx32(r32)};
                    end
                end else begin
                    case (r_cmd.opcode)
                        OP_I64_ADD: r64 = r_rdata.v + r_top.v;
                        OP_I64_SUB: r64 = r_rdata.v - r_top.v;
                        OP_I64_AND: r64 = r_rdata.v & r_top.v;
                        OP_I64_OR:  r64 = r_rdata.v | r_top.v;
                        OP_I64_XOR: r64 = r_rdata.v ^ r_top.v;
                        OP_I64_MUL: begin
                            ok      = 1'b0;
                            n_opa   = r_rdata.v;
                            n_mstep = 2'd0;
                            n_state = S_MUL;
                        end
                        default: begin
                            ok   = 1'b0;
                            n_st = ST_ERR;
                        end
                    endcase
                    if (ok) begin
                        fin_bin = 1'b1;
                        res = {1'b1, r64};
                    end
                end
            end

            // Restoring division, one quotient bit a cycle; the dividend shifts
            // out of the low word of the accumulator as quotient bits shift in.
            S_DIV: begin
                rs   = {r_rem, r_acc[31]};
                diff = rs - {1'b0, r_dvs};
                if (!diff[32]) begin
                    n_rem = diff[31:0];
                    qv    = {r_acc[30:0], 1'b1};
                end else begin
                    n_rem = rs[31:0];
                    qv    = {r_acc[30:0], 1'b0};
                end
                n_acc = {32'd0, qv};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(31)) begin
                    fin_bin = 1'b1;
                    res     = {1'b0, sx32(r_neg ? 32'd0 - qv : qv)};
                    n_state = S_OUT;
                end
            end

            // Low 64 bits of the product from three 32x32 partial products.
            S_MUL: begin
                n_mstep = r_mstep + 1'b1;
                case (r_mstep)
                    2'd0: begin
                        mul_a = r_opa[31:0];
                        mul_b = r_top.v[31:0];
                        n_acc = mul_p;
                    end
                    2'd1: begin
                        mul_a = r_opa[31:0];
                        mul_b = r_top.v[63:32];
                        n_acc = r_acc + {mul_p[31:0], 32'd0};
                    end
                    default: begin
                        mul_a   = r_opa[63:32];
                        mul_b   = r_top.v[31:0];
                        fin_bin = 1'b1;
                        res     = {1'b1, r_acc + {mul_p[31:0], 32'd0}};
                        n_state = S_OUT;
                    end
                endcase
            end

            // Leading zeros counted a nibble per cycle.
            S_CLZ: begin
                zc = r_cnt + CNT_W'(lz4(nib));
                if (nib != 4'd0 || r_cnt == CNT_W'(28)) begin
                    fin_top = 1'b1;
                    res     = {1'b0, 64'(zc)};
                    n_state = S_OUT;
                end else begin
                    n_cnt = zc;
                    n_acc = {32'd0, r_acc[27:0], 4'd0};
                end
            end

            S_OUT: begin
                if (!r_ov || out_ch.ready) begin
                    n_ov    = 1'b1;
                    n_o_st  = r_st;
                    n_o_dep = DEPTH_W'(r_sp);
                    n_o_pk  = DEPTH_W'(r_peak);
                    if (r_popped) begin
                        n_o_val = r_pv.v;
                        n_o_t   = r_pv.t;
                    end else if (r_sp != '0) begin
                        n_o_val = r_top.v;
                        n_o_t   = r_top.t;
                    end else begin
                        n_o_val = '0;
                        n_o_t   = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        if (psh) begin
            we    = 1'b1;
            waddr = r_sp[AW-1:0];
            wdata = res;
            n_top = res;
            n_sp  = r_sp + 1'b1;
            if (r_sp + 1'b1 > r_peak) n_peak = r_sp + 1'b1;
        end
        if (fin_bin) begin
            we    = 1'b1;
            waddr = sp_m2[AW-1:0];
            wdata = res;
            n_top = res;
            n_sp  = sp_m1;
        end
        if (fin_top) begin
            we    = 1'b1;
            waddr = sp_m1[AW-1:0];
            wdata = res;
            n_top = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sp     <= '0;
            r_peak   <= '0;
            r_frame  <= 1'b0;
            r_liu    <= '0;
            r_ov     <= 1'b0;
            r_popped <= 1'b0;
            r_st     <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_sp     <= n_sp;
            r_peak   <= n_peak;
            r_frame  <= n_frame;
            r_liu    <= n_liu;
            r_ov     <= n_ov;
            r_popped <= n_popped;
            r_st     <= n_st;
        end
        r_cmd   <= n_cmd;   r_top   <= n_top;   r_pv    <= n_pv;
        r_lv    <= n_lv;    r_lt    <= n_lt;    r_cnt   <= n_cnt;
        r_acc   <= n_acc;   r_opa   <= n_opa;   r_dvs   <= n_dvs;
        r_rem   <= n_rem;   r_neg   <= n_neg;   r_mstep <= n_mstep;
        r_o_st  <= n_o_st;  r_o_val <= n_o_val; r_o_t   <= n_o_t;
        r_o_dep <= n_o_dep; r_o_pk  <= n_o_pk;
    end

endmodule

FILE: sv/wasm_stack_executor.sv
// Stack executor for an integer WebAssembly subset: front end, queue,
// execution unit and configuration registers. Depends on wse_pkg, wse_chan_if, wse_regs, wse_front and wse_back.
//
// Each item yields exactly one result word. Items enter a two-entry queue, so
// the input side can take up to two items while the execution unit works and a
// result waits in its output register. The execution unit handles one item at a
// time from its sequencer. Push, constants, local.get/tee, i32.eqz, nop, end and
// any item turned away before a stack memory read go straight from the idle state
// to the output state; pop, drop and local.set refill the cached top of stack
// through a registered read of the stack memory, skipped when the stack ends
// empty; i32/i64 binary operations fetch the lower operand through a registered
// read; i32.clz counts one nibble a cycle, i64.mul sums three 32x32 partial
// products, i32 division yields one quotient bit a cycle, and frame entry moves
// the parameters one at a time through the stack memory port, then refills the
// cached top. A result still waiting in the output register holds the sequencer
// until it is taken. There is no clearing pass after reset.
module wasm_stack_executor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wse_in_if.sink      in_ch,
    wse_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wse_pkg::*;

    t_cfg cfg;
    logic q_valid, q_ready;
    t_cmd q_cmd;

    wse_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    wse_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_ready (q_ready)
    );

    wse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_ready (q_ready),
        .out_ch    (out_ch)
    );

endmodule

FILE: sv/wse_checker.sv
// Port-level checks of the stack executor, bound to the top level.
// Depends on wse_pkg for the status codes and the stack depth.
module wse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_status,
    input logic [6:0] i_out_depth,
    input logic [6:0] i_out_peak
);
    import wse_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_peak_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_peak >= i_out_depth) && (i_out_depth <= 7'(STACK_DEPTH)))
        else $error("depth above peak or stack size");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == ST_OVF |-> i_out_depth == 7'(STACK_DEPTH))
        else $error("overflow reported on a stack that is not full");

    a_peak_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready ##1 i_out_valid |-> i_out_peak >= $past(i_out_peak))
        else $error("peak depth went down");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status)
            && $stable(i_out_depth))
        else $error("stalled result changed");

endmodule

bind wasm_stack_executor wse_checker u_wse_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (out_ch.valid),
    .i_out_ready  (out_ch.ready),
    .i_out_status (out_ch.status),
    .i_out_depth  (out_ch.stack_depth),
    .i_out_peak   (out_ch.peak_depth)
);
